>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define QXM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define QXM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/qxm_pkg.sv
// ----------------------------------------------------------------------------
// qxm_pkg
// Shared constants, register codes and types of the X-frame motor mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package qxm_pkg;

    // Fixed-point scales
    localparam int FULL_SCALE  = 10000;     // 100 percent in 0.01 units
    localparam int STATE_FULL  = 2560000;   // FULL_SCALE with 8 fraction bits
    localparam int MOTOR_CNT   = 4;
    localparam int MOT_W       = 2;

    // Pulse mapping: floor(num / STATE_FULL) = floor((num >> 10) / 2500)
    localparam int DIV_SHIFT   = 10;
    localparam int RECIP_SHIFT = 36;
    localparam int PULSE_RECIP = 27487791;  // ceil(2^36 / 2500)

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 26;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULSE_MIN      = 3'd0,
        REG_PULSE_MAX      = 3'd1,
        REG_LIMIT_RATIO    = 3'd2,
        REG_ATTITUDE_GAIN  = 3'd3,
        REG_SMOOTHING_GAIN = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [11:0] pulse_min;
        logic [11:0] pulse_max;
        logic [15:0] limit_ratio;
        logic [15:0] attitude_gain;
        logic [15:0] smoothing_gain;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        pulse_min:      12'd1000,
        pulse_max:      12'd2000,
        limit_ratio:    16'd49152,
        attitude_gain:  16'd13107,
        smoothing_gain: 16'd16384
    };

endpackage

`default_nettype wire

>>> sv/qxm_cfg_regs.sv
// ----------------------------------------------------------------------------
// qxm_cfg_regs
// Configuration register file of the motor mixer, written over the cfg port.
// ----------------------------------------------------------------------------
`default_nettype none

module qxm_cfg_regs
    import qxm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       regs
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign regs      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PULSE_MIN:      cfg_next.pulse_min      = cfg_data[11:0];
                REG_PULSE_MAX:      cfg_next.pulse_max      = cfg_data[11:0];
                REG_LIMIT_RATIO:    cfg_next.limit_ratio    = cfg_data;
                REG_ATTITUDE_GAIN:  cfg_next.attitude_gain  = cfg_data;
                REG_SMOOTHING_GAIN: cfg_next.smoothing_gain = cfg_data;
                default:            cfg_next                = cfg_reg;  // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/qxm_mul.sv
// ----------------------------------------------------------------------------
// qxm_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module qxm_mul
    import qxm_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic signed [MUL_A_W-1:0] a,
    input  wire logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0]      prod
);

    logic signed [MUL_P_W-1:0] prod_reg;
    logic signed [MUL_P_W-1:0] prod_next;

    assign prod_next = MUL_P_W'(a) * MUL_P_W'(b);
    assign prod      = prod_reg;

    // Hold the product until the next issue.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/quad_x_motor_mixer.sv
// ----------------------------------------------------------------------------
// quad_x_motor_mixer
// X-frame quadcopter motor mixer with attitude correction, per-motor output
// smoothing and a linear mapping onto ESC pulse widths.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ------------------------------------------
//  in        in_valid / in_stall    throttle, roll, pitch, yaw commands,
//                                   pitch and roll angles
//  out       out_valid / out_stall  four motor pulse widths in microseconds
//  cfg       cfg_valid / cfg_ready  cfg_index (register), cfg_data
//
//  An item runs from its transfer through four setup steps, six steps per
//  motor, one handoff step and the idle step that takes the next transfer,
//  and only then can the next item be taken. The pace is set by the single
//  25x26 multiplier, which forms sixteen products per item, at most one per
//  step, each registered before use.
//  Reset clears the four smoothed motor values and loads the register
//  defaults. The result waits in an output register; while it is stalled
//  the next item still runs and holds in the handoff step until it drains.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_x_motor_mixer
    import qxm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [13:0]           throttle_command,
    input  wire logic signed [14:0]    roll_command,
    input  wire logic signed [14:0]    pitch_command,
    input  wire logic signed [14:0]    yaw_command,
    input  wire logic signed [15:0]    pitch_angle,
    input  wire logic signed [15:0]    roll_angle,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [11:0]                pulse_rear_right,
    output logic [11:0]                pulse_front_right,
    output logic [11:0]                pulse_rear_left,
    output logic [11:0]                pulse_front_left,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------------
    // Sequencer states, one-hot
    // ------------------------------------------------------------------------
    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,   // wait for an item
        ST_LIM  = 12'b0000_0000_0010,   // issue throttle * limit_ratio
        ST_PANG = 12'b0000_0000_0100,   // take limit, issue pitch angle * gain
        ST_RANG = 12'b0000_0000_1000,   // take pitch fix, issue roll angle * gain
        ST_MIX  = 12'b0000_0001_0000,   // take roll fix, mix targets, issue base
        ST_SMUL = 12'b0000_0010_0000,   // issue (target - state) * smoothing
        ST_SUPD = 12'b0000_0100_0000,   // update smoothed state
        ST_PMUL = 12'b0000_1000_0000,   // issue state * span
        ST_PADD = 12'b0001_0000_0000,   // add base, scale down
        ST_DMUL = 12'b0010_0000_0000,   // issue divide by reciprocal
        ST_DOUT = 12'b0100_0000_0000,   // take pulse width, next motor
        ST_DONE = 12'b1000_0000_0000    // hand result to the output register
    } state_t;

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    // Clamp a command to +-100 percent and halve it toward zero.
    function automatic logic signed [13:0] half_cmd(input logic signed [14:0] c);
        logic signed [14:0] cl;
        logic signed [14:0] adj;
        if (c > 15'sd10000)
            cl = 15'sd10000;
        else if (c < -15'sd10000)
            cl = -15'sd10000;
        else
            cl = c;
        adj      = cl + {14'd0, cl[14]};
        half_cmd = 14'(adj >>> 1);
    endfunction

    // Bound an axis term to +-limit.
    function automatic logic signed [13:0] clamp_lim(input logic signed [13:0] v,
                                                     input logic [13:0] lim);
        logic signed [14:0] v_w;
        logic signed [14:0] lim_w;
        v_w   = 15'(v);
        lim_w = signed'({1'b0, lim});
        if (v_w > lim_w)
            clamp_lim = 14'(lim_w);
        else if (v_w < -lim_w)
            clamp_lim = 14'(-lim_w);
        else
            clamp_lim = v;
    endfunction

    // Clamp a motor sum to 0..100 percent.
    function automatic logic [13:0] clamp_pct(input logic signed [18:0] v);
        if (v[18])
            clamp_pct = '0;
        else if (v > 19'(FULL_SCALE))
            clamp_pct = 14'(FULL_SCALE);
        else
            clamp_pct = v[13:0];
    endfunction

    // Product scaled by 2^-16, truncated toward zero.
    function automatic logic signed [MUL_P_W-17:0] q16_trunc(
        input logic signed [MUL_P_W-1:0] p);
        logic signed [MUL_P_W-1:0] adj;
        adj       = p + (p[MUL_P_W-1] ? MUL_P_W'(17'h0FFFF) : MUL_P_W'(17'h00000));
        q16_trunc = adj[MUL_P_W-1:16];
    endfunction

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    cfg_t cfg;

    qxm_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (cfg)
    );

    // ------------------------------------------------------------------------
    // Shared multiplier
    // ------------------------------------------------------------------------
    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    qxm_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p)
    );

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    state_t                   state_reg,    state_next;
    logic [MOT_W-1:0]         mot_reg,      mot_next;
    logic                     out_valid_reg, out_valid_next;
    logic [21:0]              s_reg  [MOTOR_CNT];
    logic [21:0]              s_next [MOTOR_CNT];

    logic [13:0]              t_reg,        t_next;
    logic signed [13:0]       yaw_h_reg,    yaw_h_next;
    logic signed [13:0]       npitch_h_reg, npitch_h_next;
    logic signed [13:0]       nroll_h_reg,  nroll_h_next;
    logic signed [15:0]       pang_reg,     pang_next;
    logic signed [15:0]       rang_reg,     rang_next;
    logic [13:0]              lim_reg,      lim_next;
    logic signed [15:0]       pcorr_reg,    pcorr_next;
    logic [13:0]              m_reg  [MOTOR_CNT];
    logic [13:0]              m_next [MOTOR_CNT];
    logic [33:0]              base_reg,     base_next;
    logic [21:0]              s_cur_reg,    s_cur_next;
    logic [23:0]              x_reg,        x_next;
    logic [11:0]              pw_reg  [MOTOR_CNT];
    logic [11:0]              pw_next [MOTOR_CNT];
    logic [11:0]              out_pw_reg  [MOTOR_CNT];
    logic [11:0]              out_pw_next [MOTOR_CNT];

    // ------------------------------------------------------------------------
    // Datapath terms
    // ------------------------------------------------------------------------
    logic signed [MUL_P_W-17:0] p_q16;
    logic signed [13:0]         yaw_lim;
    logic signed [18:0]         t_w;
    logic signed [18:0]         yaw_w;
    logic signed [18:0]         pf_w;
    logic signed [18:0]         rr_w;
    logic signed [18:0]         tgt [MOTOR_CNT];
    logic signed [22:0]         diff;
    logic signed [23:0]         s_sum;
    logic [21:0]                s_new;
    logic signed [12:0]         span;
    logic signed [35:0]         num;

    assign p_q16   = q16_trunc(mul_p);
    assign yaw_lim = clamp_lim(yaw_h_reg, lim_reg);
    assign t_w     = signed'({5'd0, t_reg});
    assign yaw_w   = 19'(yaw_lim);
    // Pitch and roll terms: bounded command half plus angle correction.
    assign pf_w    = 19'(clamp_lim(npitch_h_reg, lim_reg)) + 19'(pcorr_reg);
    assign rr_w    = 19'(clamp_lim(nroll_h_reg, lim_reg)) + 19'(signed'(p_q16[15:0]));

    // X-frame mix: rear right, front right, rear left, front left.
    assign tgt[0]  = t_w - pf_w + rr_w + yaw_w;
    assign tgt[1]  = t_w + pf_w + rr_w - yaw_w;
    assign tgt[2]  = t_w - pf_w - rr_w - yaw_w;
    assign tgt[3]  = t_w + pf_w - rr_w + yaw_w;

    // Smoothing step of the current motor.
    assign diff    = signed'({1'b0, m_reg[mot_reg], 8'd0}) - signed'({1'b0, s_reg[mot_reg]});
    assign s_sum   = signed'({2'b0, s_reg[mot_reg]}) + 24'(p_q16);
    assign s_new   = s_sum[23] ? '0 :
                     (s_sum > 24'(STATE_FULL)) ? 22'(STATE_FULL) : s_sum[21:0];

    // Pulse mapping: base + state * span, never below zero.
    assign span    = signed'({1'b0, cfg.pulse_max}) - signed'({1'b0, cfg.pulse_min});
    assign num     = signed'({2'b0, base_reg}) + 36'(mul_p);

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        mot_next       = mot_reg;
        out_valid_next = out_valid_reg;
        t_next         = t_reg;
        yaw_h_next     = yaw_h_reg;
        npitch_h_next  = npitch_h_reg;
        nroll_h_next   = nroll_h_reg;
        pang_next      = pang_reg;
        rang_next      = rang_reg;
        lim_next       = lim_reg;
        pcorr_next     = pcorr_reg;
        base_next      = base_reg;
        s_cur_next     = s_cur_reg;
        x_next         = x_reg;
        s_next         = s_reg;
        m_next         = m_reg;
        pw_next        = pw_reg;
        out_pw_next    = out_pw_reg;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        // Drop the result once it is taken.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    t_next        = (throttle_command > 14'(FULL_SCALE)) ?
                                    14'(FULL_SCALE) : throttle_command;
                    yaw_h_next    = half_cmd(yaw_command);
                    npitch_h_next = -half_cmd(pitch_command);
                    nroll_h_next  = -half_cmd(roll_command);
                    pang_next     = pitch_angle;
                    rang_next     = roll_angle;
                    state_next    = ST_LIM;
                end
            end
            ST_LIM:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(t_reg);
                mul_b      = MUL_B_W'(cfg.limit_ratio);
                state_next = ST_PANG;
            end
            ST_PANG:
            begin
                lim_next   = mul_p[29:16];
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(pang_reg);
                mul_b      = MUL_B_W'(cfg.attitude_gain);
                state_next = ST_RANG;
            end
            ST_RANG:
            begin
                pcorr_next = signed'(p_q16[15:0]);
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(rang_reg);
                mul_b      = MUL_B_W'(cfg.attitude_gain);
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                for (int i = 0; i < MOTOR_CNT; i++)
                begin
                    m_next[i] = clamp_pct(tgt[i]);
                end
                // Pulse base pulse_min * STATE_FULL, taken by the first motor.
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(cfg.pulse_min);
                mul_b      = MUL_B_W'(STATE_FULL);
                mot_next   = '0;
                state_next = ST_SMUL;
            end
            ST_SMUL:
            begin
                if (mot_reg == '0)
                begin
                    base_next = mul_p[33:0];
                end
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(diff);
                mul_b      = MUL_B_W'(cfg.smoothing_gain);
                state_next = ST_SUPD;
            end
            ST_SUPD:
            begin
                s_next[mot_reg] = s_new;
                s_cur_next      = s_new;
                state_next      = ST_PMUL;
            end
            ST_PMUL:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(s_cur_reg);
                mul_b      = MUL_B_W'(span);
                state_next = ST_PADD;
            end
            ST_PADD:
            begin
                x_next     = num[35] ? '0 : num[33:DIV_SHIFT];
                state_next = ST_DMUL;
            end
            ST_DMUL:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(x_reg);
                mul_b      = MUL_B_W'(PULSE_RECIP);
                state_next = ST_DOUT;
            end
            ST_DOUT:
            begin
                pw_next[mot_reg] = mul_p[RECIP_SHIFT+11:RECIP_SHIFT];
                if (mot_reg == MOT_W'(MOTOR_CNT - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mot_next   = mot_reg + 1'b1;
                    state_next = ST_SMUL;
                end
            end
            ST_DONE:
            begin
                // Load the output register once the previous result is gone.
                if (!out_valid_reg || !out_stall)
                begin
                    out_pw_next    = pw_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and smoothed state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mot_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MOTOR_CNT; i++)
            begin
                s_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            mot_reg       <= mot_next;
            out_valid_reg <= out_valid_next;
            s_reg         <= s_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        yaw_h_reg    <= yaw_h_next;
        npitch_h_reg <= npitch_h_next;
        nroll_h_reg  <= nroll_h_next;
        pang_reg     <= pang_next;
        rang_reg     <= rang_next;
        lim_reg      <= lim_next;
        pcorr_reg    <= pcorr_next;
        base_reg     <= base_next;
        s_cur_reg    <= s_cur_next;
        x_reg        <= x_next;
        m_reg        <= m_next;
        pw_reg       <= pw_next;
        out_pw_reg   <= out_pw_next;
    end

    // ------------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------------
    assign in_stall          = (state_reg != ST_IDLE);
    assign out_valid         = out_valid_reg;
    assign pulse_rear_right  = out_pw_reg[0];
    assign pulse_front_right = out_pw_reg[1];
    assign pulse_rear_left   = out_pw_reg[2];
    assign pulse_front_left  = out_pw_reg[3];

endmodule

`default_nettype wire

>>> sv/qxm_checker.sv
// ----------------------------------------------------------------------------
// qxm_checker
// Port-level checks of the motor mixer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module qxm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [11:0] pulse_rear_right,
    input wire logic [11:0] pulse_front_right,
    input wire logic [11:0] pulse_rear_left,
    input wire logic [11:0] pulse_front_left
);

    // The block is busy right after it takes an item.
    `QXM_ASSERT_NXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall, "input taken while busy")

    // No result can appear in the cycle after an input transfer.
    `QXM_ASSERT_NXT(a_no_early_out, clk, rst_n, in_valid && !in_stall, !$rose(out_valid), "result too early")

    // A new result comes only from the handoff step, while the input is stalled.
    `QXM_ASSERT_IMP(a_out_from_busy, clk, rst_n, $rose(out_valid), $past(in_stall), "result while idle")

    // A stalled result holds.
    `QXM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable({pulse_rear_right, pulse_front_right, pulse_rear_left, pulse_front_left}), "stalled result changed")

endmodule

bind quad_x_motor_mixer qxm_checker u_qxm_checker (.*);

`default_nettype wire

>>> bench/quad_x_motor_mixer_test.sv
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_test
// Self-checking bench for the X-frame motor mixer. Drives command items and
// register writes and predicts the four pulse widths with a fixed-point
// model that has its own smoothed motor state. Compares every result in
// order, under several register settings and with both sides idling.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_x_motor_mixer_test;

    timeunit 1ns;
    timeprecision 1ps;

    import qxm_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_CYCLES  = 40;    // longer than one item's run through the mixer
    localparam int HOLD_CYCLES   = 500;
    localparam int PHASE_ITEMS   = 200;
    localparam int PRESSURE_ITEMS = 24;

    typedef struct packed {
        logic [13:0]        throttle;
        logic signed [14:0] roll;
        logic signed [14:0] pitch;
        logic signed [14:0] yaw;
        logic signed [15:0] pitch_ang;
        logic signed [15:0] roll_ang;
    } command_t;

    // Motor order: rear right, front right, rear left, front left
    typedef logic [MOTOR_CNT-1:0][11:0] pulse_set_t;

    class motor_mix_checker;
        cfg_t       settings;
        longint     smoothed [MOTOR_CNT];
        pulse_set_t pending_pulses [$];
        int         mismatches;

        function new();
            settings   = CFG_RESET;
            mismatches = 0;
            foreach (smoothed[i]) smoothed[i] = 0;
        endfunction

        function longint bound(longint v, longint lo, longint hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PULSE_MIN:      settings.pulse_min      = data[11:0];
                REG_PULSE_MAX:      settings.pulse_max      = data[11:0];
                REG_LIMIT_RATIO:    settings.limit_ratio    = data;
                REG_ATTITUDE_GAIN:  settings.attitude_gain  = data;
                REG_SMOOTHING_GAIN: settings.smoothing_gain = data;
                default: ;
            endcase
        endfunction

        // Work out the four pulse widths for one command and queue them.
        function void mix_command(command_t c);
            longint thr, roll, pitch, yawc, lim, yaw, pf, rr, span, num, m, gain;
            longint tgt [MOTOR_CNT];
            pulse_set_t p;
            thr   = bound(longint'(c.throttle), 0, FULL_SCALE);
            roll  = bound(longint'($signed(c.roll)), -FULL_SCALE, FULL_SCALE);
            pitch = bound(longint'($signed(c.pitch)), -FULL_SCALE, FULL_SCALE);
            yawc  = bound(longint'($signed(c.yaw)), -FULL_SCALE, FULL_SCALE);
            gain  = longint'(settings.attitude_gain);
            lim   = (thr * longint'(settings.limit_ratio)) / 65536;
            yaw   = bound(yawc / 2, -lim, lim);
            pf    = bound(-pitch / 2, -lim, lim)
                    + (longint'($signed(c.pitch_ang)) * gain) / 65536;
            rr    = bound(-roll / 2, -lim, lim)
                    + (longint'($signed(c.roll_ang)) * gain) / 65536;
            tgt[0] = thr - pf + rr + yaw;
            tgt[1] = thr + pf + rr - yaw;
            tgt[2] = thr - pf - rr - yaw;
            tgt[3] = thr + pf - rr + yaw;
            span = longint'(settings.pulse_max) - longint'(settings.pulse_min);
            for (int i = 0; i < MOTOR_CNT; i++) begin
                m = bound(tgt[i], 0, FULL_SCALE) * 256;
                smoothed[i] = bound(smoothed[i]
                              + ((m - smoothed[i]) * longint'(settings.smoothing_gain)) / 65536,
                              0, STATE_FULL);
                num = longint'(settings.pulse_min) * STATE_FULL + smoothed[i] * span;
                if (num < 0) num = 0;
                p[i] = 12'(num / STATE_FULL);
            end
            pending_pulses.push_back(p);
        endfunction

        task report(string what);
            $display("%0t mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_pulses(pulse_set_t got);
            string motor_name [MOTOR_CNT] = '{"pulse_rear_right", "pulse_front_right",
                                              "pulse_rear_left", "pulse_front_left"};
            pulse_set_t want;
            if (pending_pulses.size() == 0) begin
                report("result with no command pending");
                return;
            end
            want = pending_pulses.pop_front();
            for (int i = 0; i < MOTOR_CNT; i++)
                if (got[i] !== want[i])
                    report($sformatf("%s got %0d expected %0d",
                                     motor_name[i], got[i], want[i]));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [13:0]           throttle_command;
    logic signed [14:0]    roll_command;
    logic signed [14:0]    pitch_command;
    logic signed [14:0]    yaw_command;
    logic signed [15:0]    pitch_angle;
    logic signed [15:0]    roll_angle;
    logic                  out_valid;
    logic                  out_stall;
    logic [11:0]           pulse_rear_right;
    logic [11:0]           pulse_front_right;
    logic [11:0]           pulse_rear_left;
    logic [11:0]           pulse_front_left;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    motor_mix_checker mixer_check = new();

    int stall_pct;      // receiver stall chance per cycle, in percent
    bit hold_go;        // request a long receiver hold-off
    bit holding;        // hold-off in progress
    int cycle_count;

    quad_x_motor_mixer dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .throttle_command  (throttle_command),
        .roll_command      (roll_command),
        .pitch_command     (pitch_command),
        .yaw_command       (yaw_command),
        .pitch_angle       (pitch_angle),
        .roll_angle        (roll_angle),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .pulse_rear_right  (pulse_rear_right),
        .pulse_front_right (pulse_front_right),
        .pulse_rear_left   (pulse_rear_left),
        .pulse_front_left  (pulse_front_left),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[quad_x_motor_mixer] ERROR");
            $finish;
        end
    end

    // Receiver: stall at random, or hold the whole stretch during a hold-off.
    always @(negedge clk)
        out_stall <= holding || ($urandom_range(99) < stall_pct);

    // Hold-off: count the long stall in cycles, then release.
    always
    begin
        wait (hold_go);
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
        hold_go = 1'b0;
    end

    // Check every result transfer against the oldest prediction.
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            mixer_check.check_pulses({pulse_front_left, pulse_rear_left,
                                      pulse_front_right, pulse_rear_right});

    function automatic command_t make_command(int thr, int roll, int pitch, int yaw,
                                              int pang, int rang);
        command_t c;
        c.throttle  = 14'(thr);
        c.roll      = 15'(roll);
        c.pitch     = 15'(pitch);
        c.yaw       = 15'(yaw);
        c.pitch_ang = 16'(pang);
        c.roll_ang  = 16'(rang);
        return c;
    endfunction

    function automatic int random_axis();
        // Mostly in range; the rest covers every 15-bit pattern.
        if ($urandom_range(99) < 85)
            return int'($urandom_range(20000)) - 10000;
        return int'($signed(15'($urandom)));
    endfunction

    function automatic int random_angle();
        int r;
        r = $urandom_range(9);
        if (r < 4) return int'($urandom_range(4000)) - 2000;
        if (r < 8) return int'($urandom_range(36000)) - 18000;
        return int'($signed(16'($urandom)));
    endfunction

    function automatic command_t random_command();
        int r;
        int thr;
        r = $urandom_range(9);
        if (r < 8)       thr = $urandom_range(FULL_SCALE);
        else if (r == 8) thr = int'(14'($urandom));
        else             thr = $urandom_range(1) ? FULL_SCALE : 0;
        return make_command(thr, random_axis(), random_axis(), random_axis(),
                            random_angle(), random_angle());
    endfunction

    // Offer one command; advance the prediction once it transfers.
    task automatic send_command(command_t c, int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid         <= 1'b1;
        throttle_command <= c.throttle;
        roll_command     <= c.roll;
        pitch_command    <= c.pitch;
        yaw_command      <= c.yaw;
        pitch_angle      <= c.pitch_ang;
        roll_angle       <= c.roll_ang;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        mixer_check.mix_command(c);
        @(negedge clk);
    endtask

    // Hold cfg_valid across back-to-back writes; the caller drops it.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        mixer_check.write_register(idx, data);
        @(negedge clk);
    endtask

    // Write all registers, plus one unused index past the last, which must be ignored.
    // Upper data bits of the 12-bit registers carry noise.
    task automatic program_mixer(cfg_t c);
        write_register(REG_PULSE_MIN, {4'($urandom), c.pulse_min});
        write_register(REG_PULSE_MAX, {4'($urandom), c.pulse_max});
        write_register(REG_LIMIT_RATIO, c.limit_ratio);
        write_register(REG_ATTITUDE_GAIN, c.attitude_gain);
        write_register(REG_SMOOTHING_GAIN, c.smoothing_gain);
        write_register(CFG_IDX_W'(REG_SMOOTHING_GAIN + 1 + $urandom_range(2)),
                       16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Wait until every predicted result has transferred.
    task automatic wait_for_pulses();
        do @(negedge clk); while (mixer_check.pending_pulses.size() != 0);
    endtask

    task automatic run_phase(int count, int idle_pct, int recv_pct);
        stall_pct = recv_pct;
        repeat (count) send_command(random_command(), idle_pct);
        in_valid <= 1'b0;
        wait_for_pulses();
    endtask

    initial
    begin
        command_t directed [$];
        cfg_t     setting;
        int       idle_pct;
        int       recv_pct;

        rst_n            = 1'b0;
        in_valid         = 1'b0;
        throttle_command = '0;
        roll_command     = '0;
        pitch_command    = '0;
        yaw_command      = '0;
        pitch_angle      = '0;
        roll_angle       = '0;
        out_stall        = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        stall_pct        = 0;
        hold_go          = 1'b0;
        holding          = 1'b0;
        cycle_count      = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed items under the reset settings: field extremes, each axis
        // both ways, over-range throttle and commands, full-range angles,
        // zero limit and truncation of odd negative commands.
        directed.push_back(make_command(0, 0, 0, 0, 0, 0));
        directed.push_back(make_command(10000, 0, 0, 0, 0, 0));
        directed.push_back(make_command(16383, 0, 0, 0, 0, 0));
        directed.push_back(make_command(5000, 10000, 0, 0, 0, 0));
        directed.push_back(make_command(5000, -10000, 0, 0, 0, 0));
        directed.push_back(make_command(5000, 0, 10000, 0, 0, 0));
        directed.push_back(make_command(5000, 0, -10000, 0, 0, 0));
        directed.push_back(make_command(5000, 0, 0, 10000, 0, 0));
        directed.push_back(make_command(5000, 0, 0, -10000, 0, 0));
        directed.push_back(make_command(6000, 16383, -16384, 16383, 0, 0));
        directed.push_back(make_command(6000, -16384, 16383, -16384, 0, 0));
        directed.push_back(make_command(5000, 0, 0, 0, 18000, 0));
        directed.push_back(make_command(5000, 0, 0, 0, -18000, 0));
        directed.push_back(make_command(5000, 0, 0, 0, 0, 18000));
        directed.push_back(make_command(5000, 0, 0, 0, 0, -18000));
        directed.push_back(make_command(5000, 0, 0, 0, 32767, -32768));
        directed.push_back(make_command(5000, 0, 0, 0, -32768, 32767));
        directed.push_back(make_command(10000, 10000, 10000, 10000, 32767, 32767));
        directed.push_back(make_command(0, 10000, -10000, 10000, 0, 0));
        directed.push_back(make_command(3000, -3, 3, -1, -1, 1));
        directed.push_back(make_command(16383, 16383, 16383, 16383, 32767, 32767));
        directed.push_back(make_command(0, -16384, -16384, -16384, -32768, -32768));
        directed.push_back(make_command(7777, 1234, -4321, 999, 1500, -2500));
        foreach (directed[i]) send_command(directed[i], 0);
        in_valid <= 1'b0;
        wait_for_pulses();

        // Long receiver hold-off while the sender keeps offering, so the
        // result register and the handoff step fill and the input stalls.
        stall_pct = 0;
        hold_go   = 1'b1;
        repeat (PRESSURE_ITEMS) send_command(random_command(), 0);
        in_valid <= 1'b0;
        wait_for_pulses();

        // Random phases, each under its own settings and idle mix:
        // none, sender idle, receiver stall, both.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: setting = '{pulse_min: 12'd0, pulse_max: 12'd4095,
                               limit_ratio: 16'hFFFF, attitude_gain: 16'hFFFF,
                               smoothing_gain: 16'hFFFF};
                1: setting = '{pulse_min: 12'd4095, pulse_max: 12'd0,
                               limit_ratio: 16'd0, attitude_gain: 16'd0,
                               smoothing_gain: 16'd0};
                2: setting = CFG_RESET;
                default:
                begin
                    setting.pulse_min      = 12'($urandom);
                    setting.pulse_max      = 12'($urandom);
                    setting.limit_ratio    = 16'($urandom);
                    setting.attitude_gain  = 16'($urandom);
                    setting.smoothing_gain = $urandom_range(1) ? 16'($urandom)
                                                               : 16'($urandom_range(65535, 49152));
                end
            endcase
            program_mixer(setting);
            case (ph % 4)
                0:       begin idle_pct = 0;  recv_pct = 0;  end
                1:       begin idle_pct = 62; recv_pct = 0;  end
                2:       begin idle_pct = 0;  recv_pct = 62; end
                default: begin idle_pct = 32; recv_pct = 32; end
            endcase
            run_phase(PHASE_ITEMS, idle_pct, recv_pct);
        end

        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mixer_check.mismatches == 0)
            $display("[quad_x_motor_mixer] OK");
        else
            $display("[quad_x_motor_mixer] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
